@@ sv/frsc_pkg.sv @@
package frsc_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int CHUNK_BYTES_DEF = 8;
    localparam int FRAME_BYTES     = 12;
    localparam int N_CAND          = FRAME_BYTES + 1;
    // bytes read per scan: last candidate start plus one frame
    localparam int SCAN_BYTES      = N_CAND + FRAME_BYTES - 1;
    localparam int SCAN_CNT_W      = $clog2(SCAN_BYTES + 1);

    localparam int HDR0_OFS    = 0;
    localparam int HDR1_OFS    = 1;
    localparam int TAIL0_OFS   = 10;
    localparam int TAIL1_OFS   = 11;
    localparam int PAYLOAD_OFS = 2;
    localparam int PAYLOAD_LEN = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND   = 3'd3;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [7:0] TAIL_FIRST_RST    = 8'h0D;
    localparam logic [7:0] TAIL_SECOND_RST   = 8'h0A;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
    } cfg_t;

endpackage

@@ sv/frsc_ring.sv @@
module frsc_ring #(
    parameter int RING_DEPTH  = frsc_pkg::RING_DEPTH_DEF,
    parameter int CHUNK_BYTES = frsc_pkg::CHUNK_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [7:0]                    wr_byte,
    output logic                          chunk_done,
    output logic [$clog2(RING_DEPTH)-1:0] chunk_base,
    input  logic                          rd_en,
    input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    output logic [7:0]                    rd_byte
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    logic [7:0]    mem [RING_DEPTH];
    logic [7:0]    rdata_reg;
    logic          rok_reg;

    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] base_reg, base_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          wrapped_reg, wrapped_next;
    logic          wr_last;

    // entries are written in address order from zero, so everything below the
    // write pointer (or everything, once it has wrapped) holds real data
    assign wr_last    = (wptr_reg == AW'(RING_DEPTH - 1));
    assign chunk_done = wr_en && (fill_reg == FW'(CHUNK_BYTES - 1));
    assign chunk_base = base_reg;
    assign rd_byte    = rok_reg ? rdata_reg : 8'h00;

    always_comb
    begin
        wptr_next    = wptr_reg;
        base_next    = base_reg;
        fill_next    = fill_reg;
        wrapped_next = wrapped_reg;
        if (wr_en)
        begin
            wptr_next = wr_last ? '0 : wptr_reg + AW'(1);
            if (wr_last)
            begin
                wrapped_next = 1'b1;
            end
            if (chunk_done)
            begin
                fill_next = '0;
                base_next = wptr_next;
            end
            else
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg    <= '0;
            base_reg    <= '0;
            fill_reg    <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            wptr_reg    <= wptr_next;
            base_reg    <= base_next;
            fill_reg    <= fill_next;
            wrapped_reg <= wrapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            rok_reg   <= wrapped_reg || (rd_addr < wptr_reg);
        end
    end

endmodule

@@ sv/frsc_scan.sv @@
module frsc_scan #(
    parameter int RING_DEPTH = frsc_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(RING_DEPTH)-1:0] scan_base,
    input  frsc_pkg::cfg_t                cfg,
    output logic                          rd_en,
    output logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    input  logic [7:0]                    rd_byte,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [63:0]                   payload,
    output logic [31:0]                   good_frames,
    output logic [31:0]                   bad_scans
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = frsc_pkg::SCAN_CNT_W;
    localparam int FB = frsc_pkg::FRAME_BYTES;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic [CW-1:0] rx_cnt_reg, rx_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   good_cnt_reg, good_cnt_next;
    logic [31:0]   bad_cnt_reg, bad_cnt_next;

    logic [63:0]   pay_reg, pay_next;
    logic          out_found_reg, out_found_next;
    logic [63:0]   out_pay_reg, out_pay_next;
    logic [7:0]    win_reg [FB];
    logic [7:0]    win_shift [FB];

    logic          arrive;
    logic          cand_ok;
    logic          last_arrive;
    logic          out_free;
    logic          load;
    logic [63:0]   cand_pay;

    assign rd_en       = (state_reg == ST_SCAN) && (iss_cnt_reg < CW'(frsc_pkg::SCAN_BYTES));
    assign rd_addr     = rd_addr_reg;
    assign arrive      = rd_pend_reg && (state_reg == ST_SCAN);
    assign last_arrive = arrive && (rx_cnt_reg == CW'(frsc_pkg::SCAN_BYTES - 1));
    assign out_free    = !out_valid_reg || !out_stall;
    assign load        = (state_reg == ST_DONE) && out_free;
    assign busy        = (state_reg != ST_IDLE);

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign payload     = out_pay_reg;
    assign good_frames = good_cnt_reg;
    assign bad_scans   = bad_cnt_reg;

    // window of the last twelve bytes; oldest byte is the candidate start
    always_comb
    begin
        for (int i = 0; i < FB - 1; i++)
        begin
            win_shift[i] = win_reg[i + 1];
        end
        win_shift[FB-1] = rd_byte;
        for (int i = 0; i < frsc_pkg::PAYLOAD_LEN; i++)
        begin
            cand_pay[8*i +: 8] = win_shift[frsc_pkg::PAYLOAD_OFS + i];
        end
    end

    assign cand_ok = arrive && (rx_cnt_reg >= CW'(FB - 1))
                     && (win_shift[frsc_pkg::HDR0_OFS]  == cfg.header_first)
                     && (win_shift[frsc_pkg::HDR1_OFS]  == cfg.header_second)
                     && (win_shift[frsc_pkg::TAIL0_OFS] == cfg.tail_first)
                     && (win_shift[frsc_pkg::TAIL1_OFS] == cfg.tail_second);

    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        iss_cnt_next   = iss_cnt_reg;
        rx_cnt_next    = rx_cnt_reg;
        rd_pend_next   = rd_en;
        hit_next       = hit_reg;
        pay_next       = pay_reg;
        good_cnt_next  = good_cnt_reg;
        bad_cnt_next   = bad_cnt_reg;
        out_found_next = out_found_reg;
        out_pay_next   = out_pay_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next   = ST_SCAN;
                    rd_addr_next = scan_base;
                    iss_cnt_next = '0;
                    rx_cnt_next  = '0;
                    rd_pend_next = 1'b0;
                    hit_next     = 1'b0;
                    pay_next     = '0;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_addr_next = (rd_addr_reg == AW'(RING_DEPTH - 1)) ? '0
                                   : rd_addr_reg + AW'(1);
                    iss_cnt_next = iss_cnt_reg + CW'(1);
                end
                if (arrive)
                begin
                    rx_cnt_next = rx_cnt_reg + CW'(1);
                end
                if (cand_ok)
                begin
                    hit_next   = 1'b1;
                    pay_next   = cand_pay;
                    state_next = ST_DONE;
                end
                else if (last_arrive)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_pay_next   = pay_reg;
                    if (hit_reg)
                    begin
                        good_cnt_next = good_cnt_reg + 32'd1;
                    end
                    else
                    begin
                        bad_cnt_next = bad_cnt_reg + 32'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_addr_reg   <= '0;
            iss_cnt_reg   <= '0;
            rx_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            good_cnt_reg  <= '0;
            bad_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            iss_cnt_reg   <= iss_cnt_next;
            rx_cnt_reg    <= rx_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            good_cnt_reg  <= good_cnt_next;
            bad_cnt_reg   <= bad_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg       <= pay_next;
        out_found_reg <= out_found_next;
        out_pay_reg   <= out_pay_next;
        if (arrive)
        begin
            win_reg <= win_shift;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == ST_IDLE))
        else $error("chunk completed while a scan is in progress");

    a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_cnt_reg <= CW'(frsc_pkg::SCAN_BYTES)) && (rx_cnt_reg <= iss_cnt_reg))
        else $error("scan read counters out of range");

    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> ((good_cnt_reg + bad_cnt_reg)
                  == ($past(good_cnt_reg) + $past(bad_cnt_reg) + 32'd1)))
        else $error("a scan result must bump exactly one counter");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_pay_reg == 64'd0))
        else $error("payload must be zero when no frame was found");

    a_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(load))
        else $error("result shown without a finished scan");

endmodule

@@ sv/ring_buffer_frame_sync_scanner.sv @@
// Channel   Signals                                       Direction
// input     in_valid, in_stall, rx_byte                   one received byte in
// output    out_valid, out_stall, found, payload,         one scan result per chunk
//           good_frames, bad_scans
// config    cfg_we, cfg_index, cfg_data                   pattern byte writes
//
// A byte that does not complete a chunk is taken whenever in_stall is low.
// The byte that completes a chunk starts a scan: 13 to 24 ring reads, one per
// cycle through the single read port, each byte coming back from a registered
// read, then the result is loaded; in_stall stays high until that load.
// The ring needs no clearing pass after reset; unwritten entries read as zero.
// A stalled result holds; bytes keep flowing until the next chunk is complete.
module ring_buffer_frame_sync_scanner #(
    parameter int RING_DEPTH  = frsc_pkg::RING_DEPTH_DEF,
    parameter int CHUNK_BYTES = frsc_pkg::CHUNK_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [63:0]                    payload,
    output logic [31:0]                    good_frames,
    output logic [31:0]                    bad_scans,
    input  logic                           cfg_we,
    input  logic [frsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frsc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);

    frsc_pkg::cfg_t cfg_reg, cfg_next;

    logic          busy;
    logic          in_xact;
    logic          chunk_done;
    logic [AW-1:0] chunk_base;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_byte;

    assign in_stall = busy;
    assign in_xact  = in_valid && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                frsc_pkg::REG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                frsc_pkg::REG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                frsc_pkg::REG_TAIL_FIRST:    cfg_next.tail_first    = cfg_data;
                frsc_pkg::REG_TAIL_SECOND:   cfg_next.tail_second   = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= frsc_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second <= frsc_pkg::HEADER_SECOND_RST;
            cfg_reg.tail_first    <= frsc_pkg::TAIL_FIRST_RST;
            cfg_reg.tail_second   <= frsc_pkg::TAIL_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    frsc_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (in_xact),
        .wr_byte    (rx_byte),
        .chunk_done (chunk_done),
        .chunk_base (chunk_base),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_byte    (rd_byte)
    );

    frsc_scan #(
        .RING_DEPTH (RING_DEPTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (chunk_done),
        .scan_base   (chunk_base),
        .cfg         (cfg_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_byte     (rd_byte),
        .busy        (busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .payload     (payload),
        .good_frames (good_frames),
        .bad_scans   (bad_scans)
    );

endmodule

@@ tb/tb_ring_buffer_frame_sync_scanner.sv @@
`timescale 1ns / 1ps

module tb_ring_buffer_frame_sync_scanner;

    localparam int RING        = frsc_pkg::RING_DEPTH_DEF;
    localparam int CHUNK       = frsc_pkg::CHUNK_BYTES_DEF;
    localparam int IDX_W       = frsc_pkg::CFG_IDX_W;
    localparam int DATA_W      = frsc_pkg::CFG_DATA_W;
    localparam int IDLE_PCT    = 6;
    localparam int DRAIN_WAIT  = 40;
    localparam int HANG_LIMIT  = 5000;
    localparam int PHASES      = 7;
    localparam int PHASE_BYTES = 245;

    typedef struct packed {
        logic        found;
        logic [63:0] payload;
        logic [31:0] good_frames;
        logic [31:0] bad_scans;
    } scan_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [63:0]           payload;
    logic [31:0]           good_frames;
    logic [31:0]           bad_scans;
    logic                  cfg_we;
    logic [IDX_W-1:0]      cfg_index;
    logic [DATA_W-1:0]     cfg_data;

    // scanner mirror
    logic [7:0]        ring_mirror [RING] = '{default: 8'h00};
    int                base_m = 0;
    int                fill_m = 0;
    logic [31:0]       good_m = '0;
    logic [31:0]       bad_m = '0;
    frsc_pkg::cfg_t    pattern;
    scan_result_t      scan_q [$];
    scan_result_t      want;

    logic [7:0]   byte_q [$];
    int           bytes_queued;
    int           bytes_taken = 0;
    logic         byte_taken = 1'b0;
    logic         result_taken = 1'b0;
    logic         steady;
    int           hang_cycles = 0;
    int           errors = 0;
    int           results_seen = 0;
    int           hits = 0;
    int           reg_writes;

    ring_buffer_frame_sync_scanner uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .payload     (payload),
        .good_frames (good_frames),
        .bad_scans   (bad_scans),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] ring_byte(input int start, input int ofs);
        return ring_mirror[(start + ofs) % RING];
    endfunction

    // store one byte; on a full chunk, scan forward from the chunk base
    function automatic void absorb_byte(input logic [7:0] b);
        scan_result_t r;
        int start;
        ring_mirror[(base_m + fill_m) % RING] = b;
        fill_m++;
        if (fill_m < CHUNK)
            return;
        fill_m = 0;
        r = '0;
        for (int c = 0; c < frsc_pkg::N_CAND && !r.found; c++)
        begin
            start = (base_m + c) % RING;
            if (ring_byte(start, frsc_pkg::HDR0_OFS) == pattern.header_first &&
                ring_byte(start, frsc_pkg::HDR1_OFS) == pattern.header_second &&
                ring_byte(start, frsc_pkg::TAIL0_OFS) == pattern.tail_first &&
                ring_byte(start, frsc_pkg::TAIL1_OFS) == pattern.tail_second)
            begin
                for (int i = 0; i < frsc_pkg::PAYLOAD_LEN; i++)
                    r.payload[8*i +: 8] = ring_byte(start, frsc_pkg::PAYLOAD_OFS + i);
                r.found = 1'b1;
            end
        end
        if (r.found)
            good_m++;
        else
            bad_m++;
        r.good_frames = good_m;
        r.bad_scans   = bad_m;
        base_m = (base_m + CHUNK) % RING;
        scan_q.push_back(r);
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    // mostly well-formed frames for the current pattern, some broken, some noise
    task automatic queue_traffic(input int n);
        logic [7:0] frame [frsc_pkg::FRAME_BYTES];
        int marks [4] = '{frsc_pkg::HDR0_OFS, frsc_pkg::HDR1_OFS,
                          frsc_pkg::TAIL0_OFS, frsc_pkg::TAIL1_OFS};
        int pick;
        int first;
        first = bytes_queued;
        while (bytes_queued - first < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                frame[frsc_pkg::HDR0_OFS]  = pattern.header_first;
                frame[frsc_pkg::HDR1_OFS]  = pattern.header_second;
                frame[frsc_pkg::TAIL0_OFS] = pattern.tail_first;
                frame[frsc_pkg::TAIL1_OFS] = pattern.tail_second;
                for (int i = 0; i < frsc_pkg::PAYLOAD_LEN; i++)
                    frame[frsc_pkg::PAYLOAD_OFS + i] = 8'($urandom_range(0, 255));
                if (pick >= 75)
                    frame[marks[$urandom_range(0, 3)]] ^= 8'($urandom_range(1, 255));
                foreach (frame[i])
                    queue_byte(frame[i]);
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            frsc_pkg::REG_HEADER_FIRST:  pattern.header_first  = val;
            frsc_pkg::REG_HEADER_SECOND: pattern.header_second = val;
            frsc_pkg::REG_TAIL_FIRST:    pattern.tail_first    = val;
            frsc_pkg::REG_TAIL_SECOND:   pattern.tail_second   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    // all four pattern bytes, plus a write to an unmapped index that must be ignored
    task automatic set_pattern(input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] t0, input logic [7:0] t1);
        write_reg(frsc_pkg::REG_HEADER_FIRST, h0);
        write_reg(frsc_pkg::REG_HEADER_SECOND, h1);
        write_reg(frsc_pkg::REG_TAIL_FIRST, t0);
        write_reg(frsc_pkg::REG_TAIL_SECOND, t1);
        write_reg(frsc_pkg::REG_TAIL_SECOND + IDX_W'($urandom_range(1, 4)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_taken != bytes_queued || scan_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic queue_list(input logic [7:0] bytes [CHUNK]);
        @(posedge clk);
        foreach (bytes[i])
            queue_byte(bytes[i]);
    endtask

    // driver: new transaction on the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || byte_taken)
            begin
                if (byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= byte_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_taken   = in_valid && !in_stall;
            result_taken = out_valid && !out_stall;
            if (byte_taken)
            begin
                absorb_byte(rx_byte);
                bytes_taken++;
            end
            if (result_taken)
            begin
                results_seen++;
                if (scan_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected scan result: found=%0b payload=%h good=%0d bad=%0d",
                                 found, payload, good_frames, bad_scans);
                end
                else
                begin
                    want = scan_q.pop_front();
                    if (want.found)
                        hits++;
                    if (found !== want.found || payload !== want.payload ||
                        good_frames !== want.good_frames || bad_scans !== want.bad_scans)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"scan %0d mismatch: exp found=%0b payload=%h good=%0d ",
                                      "bad=%0d, got found=%0b payload=%h good=%0d bad=%0d"},
                                     results_seen, want.found, want.payload, want.good_frames,
                                     want.bad_scans, found, payload, good_frames, bad_scans);
                    end
                end
            end
            if (byte_taken || result_taken || cfg_we)
                hang_cycles = 0;
            else
            begin
                hang_cycles++;
                if (hang_cycles >= HANG_LIMIT)
                begin
                    $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        reg_writes   = 0;
        bytes_queued = 0;
        pattern = '{frsc_pkg::HEADER_FIRST_RST, frsc_pkg::HEADER_SECOND_RST,
                    frsc_pkg::TAIL_FIRST_RST, frsc_pkg::TAIL_SECOND_RST};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset pattern: head of a frame whose tail is not yet there -> no match
        queue_list('{8'hAA, 8'h55, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20});
        wait_drained();
        // all-zero pattern matches against unwritten ring entries, which read as zero
        set_pattern(8'h00, 8'h00, 8'h00, 8'h00);
        queue_list('{8'h00, 8'h00, 8'h40, 8'h80, 8'hFF, 8'hFF, 8'h7F, 8'hFE});
        wait_drained();
        set_pattern(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_list('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_pattern(frsc_pkg::HEADER_FIRST_RST, frsc_pkg::HEADER_SECOND_RST,
                               frsc_pkg::TAIL_FIRST_RST, frsc_pkg::TAIL_SECOND_RST);
                1: set_pattern(8'h00, 8'h00, 8'h00, 8'h00);
                2: set_pattern(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                default: set_pattern(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            @(posedge clk);
            steady = (ph == 3);
            queue_traffic(PHASE_BYTES);
            wait_drained();
        end
        steady = 1'b0;

        $display("covered %0d bytes and %0d chunk scans (%0d with a frame found)",
                 bytes_taken, results_seen, hits);
        $display("%0d register writes over %0d pattern settings, %0d mismatches",
                 reg_writes, PHASES + 2, errors);
        if (errors == 0 && scan_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
